[design/hhf_pkg.sv]
package hhf_pkg;

  localparam int SHARDS = 8;
  localparam int NODES  = 16;

  localparam int NODE_W  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int SHARD_W = (SHARDS > 1) ? $clog2(SHARDS) : 1;

  localparam int IDX_W    = 4;
  localparam int HEALTH_W = 2;
  localparam int MISS_W   = 8;
  localparam int THR_W    = 8;
  localparam int CNT_W    = 4;
  localparam int FSHARD_W = 3;
  localparam int EPOCH_W  = 32;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [THR_W-1:0]   SUSPECT_RST = THR_W'(2);
  localparam logic [THR_W-1:0]   DOWN_RST    = THR_W'(3);
  localparam logic               BACKUP_RST  = 1'b1;
  localparam logic [CNT_W-1:0]   SHARDS_RST  = CNT_W'(8);
  localparam logic [EPOCH_W-1:0] EPOCH_RST   = EPOCH_W'(1);

  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  localparam logic [2:0] REG_SUSPECT = 3'd0;
  localparam logic [2:0] REG_DOWN    = 3'd1;
  localparam logic [2:0] REG_BACKUPS = 3'd2;
  localparam logic [2:0] REG_SHARDS  = 3'd3;
  localparam logic [2:0] REG_EPOCH   = 3'd4;

  typedef enum logic [HEALTH_W-1:0] {
    H_HEALTHY = 2'd0,
    H_SUSPECT = 2'd1,
    H_DOWN    = 2'd2
  } health_t;

  typedef struct packed {
    logic [THR_W-1:0] suspect_after;
    logic [THR_W-1:0] down_after;
    logic [CNT_W-1:0] shards_in_use;
  } cfg_t;

  typedef struct packed {
    logic               epoch_ld;
    logic [EPOCH_W-1:0] epoch_val;
    logic               backup_ld;
    logic               backup_val;
  } cfg_ld_t;

  typedef struct packed {
    logic in_ready;
    logic take;
    logic update;
    logic check;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_room;
  } status_t;

endpackage

[design/hhf_if.sv]
interface hhf_in_if;
  logic                     valid;
  logic                     ready;
  logic [hhf_pkg::IDX_W-1:0] node_index;
  logic                     node_alive;

  modport source (output valid, output node_index, output node_alive, input ready);
  modport sink (input valid, input node_index, input node_alive, output ready);
endinterface

interface hhf_out_if;
  logic                         valid;
  logic                         ready;
  logic [hhf_pkg::HEALTH_W-1:0] health_state;
  logic [hhf_pkg::MISS_W-1:0]   miss_total;
  logic                         state_changed;
  logic                         failover_done;
  logic [hhf_pkg::FSHARD_W-1:0] failover_shard;
  logic [hhf_pkg::IDX_W-1:0]    new_primary;
  logic [hhf_pkg::EPOCH_W-1:0]  map_epoch;

  modport source (output valid, output health_state, output miss_total,
                  output state_changed, output failover_done, output failover_shard,
                  output new_primary, output map_epoch, input ready);
  modport sink (input valid, input health_state, input miss_total,
                input state_changed, input failover_done, input failover_shard,
                input new_primary, input map_epoch, output ready);
endinterface

[design/hhf_regs.sv]
module hhf_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hhf_pkg::ADDR_W-1:0]    paddr,
  input  logic [hhf_pkg::DATA_W-1:0]    pwdata,
  output logic [hhf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output hhf_pkg::cfg_t                 cfg,
  output hhf_pkg::cfg_ld_t              ld
);
  import hhf_pkg::*;

  logic [THR_W-1:0]   suspect_r;
  logic [THR_W-1:0]   down_r;
  logic               backups_r;
  logic [CNT_W-1:0]   shards_r;
  logic [EPOCH_W-1:0] epoch_start_r;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      suspect_r     <= SUSPECT_RST;
      down_r        <= DOWN_RST;
      backups_r     <= BACKUP_RST;
      shards_r      <= SHARDS_RST;
      epoch_start_r <= EPOCH_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SUSPECT: suspect_r     <= pwdata[THR_W-1:0];
        REG_DOWN:    down_r        <= pwdata[THR_W-1:0];
        REG_BACKUPS: backups_r     <= pwdata[0];
        REG_SHARDS:  shards_r      <= pwdata[CNT_W-1:0];
        REG_EPOCH:   epoch_start_r <= pwdata[EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SUSPECT: prdata = DATA_W'(suspect_r);
      REG_DOWN:    prdata = DATA_W'(down_r);
      REG_BACKUPS: prdata = DATA_W'(backups_r);
      REG_SHARDS:  prdata = DATA_W'(shards_r);
      REG_EPOCH:   prdata = DATA_W'(epoch_start_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.suspect_after = suspect_r;
  assign cfg.down_after    = down_r;
  assign cfg.shards_in_use = shards_r;

  assign ld.epoch_ld   = wr_en && (reg_idx == REG_EPOCH);
  assign ld.epoch_val  = pwdata[EPOCH_W-1:0];
  assign ld.backup_ld  = wr_en && (reg_idx == REG_BACKUPS);
  assign ld.backup_val = pwdata[0];

endmodule

[design/hhf_ctrl.sv]
module hhf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  hhf_pkg::status_t status,
  output hhf_pkg::cmd_t    cmd
);
  import hhf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UPD  = 4'b0010,
    S_CHK  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (status.in_valid) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_CHK;
      S_CHK:  state_nxt = S_FIN;
      S_FIN:  if (status.out_room) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.in_ready = (state_r == S_IDLE);
  assign cmd.take     = (state_r == S_IDLE) && status.in_valid;
  assign cmd.update   = (state_r == S_UPD);
  assign cmd.check    = (state_r == S_CHK);
  assign cmd.load_out = (state_r == S_FIN) && status.out_room;

endmodule

[design/hhf_dp.sv]
module hhf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  hhf_pkg::cfg_t      cfg,
  input  hhf_pkg::cfg_ld_t   ld,
  input  hhf_pkg::cmd_t      cmd,
  output hhf_pkg::status_t   status,
  hhf_in_if.sink             in_if,
  hhf_out_if.source          out_if
);
  import hhf_pkg::*;

  // per-node state
  logic [MISS_W-1:0] miss_r   [NODES];
  health_t           health_r [NODES];
  logic              ever_r   [NODES];

  // shard map
  logic [NODE_W-1:0] primary_r [SHARDS];
  logic [NODE_W-1:0] backup_r  [SHARDS];
  logic              bvalid_r  [SHARDS];
  logic [EPOCH_W-1:0] epoch_r;

  // item in flight
  logic [NODE_W-1:0]  node_r;
  logic               alive_r;
  logic               node_ok_r;
  health_t            st_r;
  logic [MISS_W-1:0]  miss_out_r;
  logic               chg_r;
  logic               trig_r;
  logic               found_r;
  logic [SHARD_W-1:0] fsh_r;
  logic               done_r;

  // result register
  logic                out_valid_r;
  health_t             o_state_r;
  logic [MISS_W-1:0]   o_miss_r;
  logic                o_chg_r;
  logic                o_done_r;
  logic [FSHARD_W-1:0] o_shard_r;
  logic [IDX_W-1:0]    o_prim_r;
  logic [EPOCH_W-1:0]  o_epoch_r;

  logic [NODE_W-1:0]  bnode;
  logic [NODE_W-1:0]  rd_addr;
  logic [MISS_W-1:0]  rd_miss;
  health_t            rd_health;
  logic               rd_ever;
  logic [MISS_W-1:0]  miss_nxt;
  health_t            health_nxt;
  logic               chg_c;
  logic               trig_c;
  logic               found_c;
  logic [SHARD_W-1:0] fsh_c;
  logic               swap;

  assign status.in_valid = in_if.valid;
  assign status.out_room = !out_valid_r || out_if.ready;
  assign in_if.ready     = cmd.in_ready;

  assign bnode     = backup_r[fsh_r];
  assign rd_addr   = cmd.check ? bnode : node_r;
  assign rd_miss   = miss_r[rd_addr];
  assign rd_health = health_r[rd_addr];
  assign rd_ever   = ever_r[rd_addr];

  always_comb begin
    if (alive_r) begin
      miss_nxt = '0;
    end else if (rd_miss == MISS_MAX) begin
      miss_nxt = rd_miss;
    end else begin
      miss_nxt = rd_miss + MISS_W'(1);
    end
    if (alive_r) begin
      health_nxt = H_HEALTHY;
    end else if (miss_nxt >= cfg.down_after) begin
      health_nxt = H_DOWN;
    end else if (miss_nxt >= cfg.suspect_after) begin
      health_nxt = H_SUSPECT;
    end else begin
      health_nxt = rd_health;
    end
  end

  assign chg_c  = node_ok_r && (health_nxt != rd_health);
  assign trig_c = chg_c && (health_nxt == H_DOWN) && (rd_ever || alive_r);

  // lowest shard in use whose primary is the probed node
  always_comb begin
    found_c = 1'b0;
    fsh_c   = '0;
    for (int s = SHARDS - 1; s >= 0; s--) begin
      if ((s < int'(cfg.shards_in_use)) && (primary_r[s] == node_r)) begin
        found_c = 1'b1;
        fsh_c   = SHARD_W'(s);
      end
    end
  end

  assign swap = cmd.check && trig_r && found_r && bvalid_r[fsh_r] &&
                (rd_health == H_HEALTHY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        miss_r[i]   <= '0;
        health_r[i] <= H_HEALTHY;
        ever_r[i]   <= 1'b0;
      end
      for (int s = 0; s < SHARDS; s++) begin
        primary_r[s] <= NODE_W'(2 * s);
        backup_r[s]  <= NODE_W'(2 * s + 1);
        bvalid_r[s]  <= BACKUP_RST;
      end
      epoch_r     <= EPOCH_RST;
      trig_r      <= 1'b0;
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld.epoch_ld) begin
        epoch_r <= ld.epoch_val;
      end
      if (ld.backup_ld) begin
        for (int s = 0; s < SHARDS; s++) begin
          bvalid_r[s] <= ld.backup_val;
        end
      end

      if (cmd.update) begin
        if (node_ok_r) begin
          miss_r[node_r]   <= miss_nxt;
          health_r[node_r] <= health_nxt;
          ever_r[node_r]   <= rd_ever | alive_r;
        end
        trig_r  <= trig_c;
        found_r <= found_c;
        fsh_r   <= fsh_c;
      end

      if (cmd.check) begin
        done_r <= swap;
        if (swap) begin
          primary_r[fsh_r] <= bnode;
          backup_r[fsh_r]  <= primary_r[fsh_r];
          epoch_r          <= epoch_r + EPOCH_W'(1);
        end
      end

      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      node_r    <= NODE_W'(in_if.node_index);
      alive_r   <= in_if.node_alive;
      node_ok_r <= (int'(in_if.node_index) < NODES);
    end
    if (cmd.update) begin
      st_r       <= node_ok_r ? health_nxt : H_HEALTHY;
      miss_out_r <= node_ok_r ? miss_nxt : '0;
      chg_r      <= chg_c;
    end
    if (cmd.load_out) begin
      o_state_r <= st_r;
      o_miss_r  <= miss_out_r;
      o_chg_r   <= chg_r;
      o_done_r  <= done_r;
      o_shard_r <= done_r ? FSHARD_W'(fsh_r) : '0;
      o_prim_r  <= done_r ? IDX_W'(primary_r[fsh_r]) : '0;
      o_epoch_r <= epoch_r;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.health_state   = o_state_r;
  assign out_if.miss_total     = o_miss_r;
  assign out_if.state_changed  = o_chg_r;
  assign out_if.failover_done  = o_done_r;
  assign out_if.failover_shard = o_shard_r;
  assign out_if.new_primary    = o_prim_r;
  assign out_if.map_epoch      = o_epoch_r;

  a_swap_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    swap |=> (epoch_r == $past(epoch_r) + EPOCH_W'(1)))
    else $error("epoch did not advance on failover");

  a_done_down: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && done_r) |-> (chg_r && (st_r == H_DOWN)))
    else $error("failover reported without a fresh down state");

  a_check_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.check |-> $past(cmd.update))
    else $error("shard check without preceding node update");

endmodule

[design/heartbeat_health_failover.sv]
// a beat is taken in idle, then update and check; finish waits for output room
// one item at a time: the sequencer walks node
//   read-modify-write, shard search and backup check/swap through one read port
// a result waiting in the output register does not block the next input beat
// reset: synchronous, active low; registers, node state, shard map and epoch
//   return to their defaults
module heartbeat_health_failover (
  input  logic                       clk,
  input  logic                       rst_n,
  hhf_in_if.sink                     in_if,
  hhf_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [hhf_pkg::ADDR_W-1:0] paddr,
  input  logic [hhf_pkg::DATA_W-1:0] pwdata,
  output logic [hhf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import hhf_pkg::*;

  cfg_t    cfg;
  cfg_ld_t ld;
  cmd_t    cmd;
  status_t status;

  hhf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .ld      (ld)
  );

  hhf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  hhf_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .ld     (ld),
    .cmd    (cmd),
    .status (status),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import hhf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 9;

  typedef struct packed {
    health_t               health;
    logic [MISS_W-1:0]     misses;
    logic                  changed;
    logic                  failover;
    logic [FSHARD_W-1:0]   shard;
    logic [IDX_W-1:0]      primary;
    logic [EPOCH_W-1:0]    epoch;
  } hb_report_t;

  class failover_map_model;
    logic [THR_W-1:0]   suspect_thr;
    logic [THR_W-1:0]   down_thr;
    logic [CNT_W-1:0]   shards_used;
    logic [EPOCH_W-1:0] epoch;
    logic [MISS_W-1:0]  misses [NODES];
    health_t            health [NODES];
    bit                 ever_up [NODES];
    logic [NODE_W-1:0]  primary [SHARDS];
    logic [NODE_W-1:0]  backup [SHARDS];
    bit                 backup_ok [SHARDS];
    hb_report_t         expected_reports [$];
    int beats, reports, changes, failovers, mismatches, reg_writes;

    function new();
      suspect_thr = SUSPECT_RST;
      down_thr = DOWN_RST;
      shards_used = SHARDS_RST;
      epoch = EPOCH_RST;
      for (int n = 0; n < NODES; n++) begin
        misses[n] = '0;
        health[n] = H_HEALTHY;
        ever_up[n] = 1'b0;
      end
      for (int s = 0; s < SHARDS; s++) begin
        primary[s] = NODE_W'(2 * s);
        backup[s] = NODE_W'(2 * s + 1);
        backup_ok[s] = BACKUP_RST;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
      reg_writes++;
      case (idx)
        REG_SUSPECT: suspect_thr = val[THR_W-1:0];
        REG_DOWN: down_thr = val[THR_W-1:0];
        REG_BACKUPS: begin
          for (int s = 0; s < SHARDS; s++) backup_ok[s] = val[0];
        end
        REG_SHARDS: shards_used = val[CNT_W-1:0];
        REG_EPOCH: epoch = val[EPOCH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_heartbeat(logic [IDX_W-1:0] node, logic alive);
      hb_report_t r;
      health_t prev;
      int used;
      logic [NODE_W-1:0] old;
      r = '0;
      beats++;
      if (node < NODES) begin
        prev = health[node];
        if (alive) begin
          misses[node] = '0;
          health[node] = H_HEALTHY;
          ever_up[node] = 1'b1;
        end else begin
          if (misses[node] != MISS_MAX) misses[node]++;
          if (misses[node] >= down_thr) health[node] = H_DOWN;
          else if (misses[node] >= suspect_thr) health[node] = H_SUSPECT;
        end
        r.health = health[node];
        r.misses = misses[node];
        r.changed = (health[node] != prev);
        if (r.changed && health[node] == H_DOWN && ever_up[node]) begin
          used = (shards_used > SHARDS) ? SHARDS : shards_used;
          for (int s = 0; s < used; s++) begin
            if (primary[s] == node) begin
              if (backup_ok[s] &&
                  (backup[s] >= NODES || health[backup[s]] == H_HEALTHY)) begin
                old = primary[s];
                primary[s] = backup[s];
                backup[s] = old;
                epoch = epoch + 1;
                r.failover = 1'b1;
                r.shard = FSHARD_W'(s);
                r.primary = IDX_W'(primary[s]);
              end
              break;
            end
          end
        end
      end
      r.epoch = epoch;
      expected_reports.insert(expected_reports.size(), r);
    endfunction

    function void check_report(hb_report_t got);
      hb_report_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report with nothing pending: st=%0d miss=%0d ep=%0h",
                   got.health, got.misses, got.epoch);
        return;
      end
      want = expected_reports.pop_front();
      reports++;
      if (want.changed) changes++;
      if (want.failover) failovers++;
      if (got.health !== want.health || got.misses !== want.misses ||
          got.changed !== want.changed || got.failover !== want.failover ||
          got.shard !== want.shard || got.primary !== want.primary ||
          got.epoch !== want.epoch) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("report %0d: exp st=%0d miss=%0d chg=%0b fo=%0b sh=%0d pri=%0d ep=%h",
                   reports, want.health, want.misses, want.changed, want.failover,
                   want.shard, want.primary, want.epoch);
          $display("report %0d: got st=%0d miss=%0d chg=%0b fo=%0b sh=%0d pri=%0d ep=%h",
                   reports, got.health, got.misses, got.changed, got.failover,
                   got.shard, got.primary, got.epoch);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  hhf_in_if  in_ch ();
  hhf_out_if out_ch ();

  failover_map_model sb = new();

  bit gaps_on;
  bit pressure_on;
  bit pressure_held;
  int burst_left;
  int hold_left;
  int pattern_mode, pattern_left, pattern_tick;
  int quiet_cycles;

  localparam logic [4:0] OPENING [24] = '{
    {1'b1, 4'd0}, {1'b0, 4'd0}, {1'b0, 4'd0}, {1'b0, 4'd0},
    {1'b1, 4'd15}, {1'b0, 4'd15},
    {1'b0, 4'd1}, {1'b0, 4'd1}, {1'b0, 4'd1},
    {1'b1, 4'd1}, {1'b0, 4'd1}, {1'b0, 4'd1}, {1'b0, 4'd1},
    {1'b1, 4'd2}, {1'b0, 4'd3}, {1'b0, 4'd3}, {1'b0, 4'd3},
    {1'b0, 4'd2}, {1'b0, 4'd2}, {1'b0, 4'd2},
    {1'b1, 4'd14}, {1'b0, 4'd14}, {1'b0, 4'd14}, {1'b0, 4'd14}
  };

  heartbeat_health_failover dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin : monitor
    hb_report_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.health   = health_t'(out_ch.health_state);
        got.misses   = out_ch.miss_total;
        got.changed  = out_ch.state_changed;
        got.failover = out_ch.failover_done;
        got.shard    = out_ch.failover_shard;
        got.primary  = out_ch.new_primary;
        got.epoch    = out_ch.map_epoch;
        sb.check_report(got);
      end
      if (in_ch.valid && in_ch.ready)
        sb.note_heartbeat(in_ch.node_index, in_ch.node_alive);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("stalled: %0d reports outstanding", sb.expected_reports.size());
        $display("[heartbeat_health_failover] ERROR");
        $finish;
      end
    end
  end

  // result side: random stall patterns plus one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    pattern_left = 0;
    pattern_tick = 0;
    forever begin
      @(posedge clk);
      pattern_tick++;
      if (pressure_on && !pressure_held) begin
        pressure_held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode = $urandom_range(0, 2);
          pattern_left = $urandom_range(10, 60);
        end
        pattern_left--;
        case (pattern_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ((pattern_tick % 7) > 2);
        endcase
      end
    end
  end

  task automatic offer_beat(input logic [IDX_W-1:0] node, input logic alive);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.node_index <= node;
    in_ch.node_alive <= alive;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // mostly revive-then-miss runs on current primaries so failovers occur
  task automatic run_episodes(input int count);
    int sent, k, s;
    logic [IDX_W-1:0] node;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          s = $urandom_range(0, SHARDS - 1);
          node = sb.primary[s];
          if ($urandom_range(0, 1)) begin
            offer_beat(sb.backup[s], 1'b1);
            sent++;
          end
          offer_beat(node, 1'b1);
          k = (sb.down_thr <= 8) ? sb.down_thr + $urandom_range(0, 2) : $urandom_range(1, 10);
          if (k == 0) k = 1;
          repeat (k) offer_beat(node, 1'b0);
          sent += k + 1;
        end
        5, 6: begin
          offer_beat(IDX_W'($urandom_range(0, NODES - 1)), 1'b1);
          sent++;
        end
        default: begin
          offer_beat(IDX_W'($urandom), 1'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    logic [THR_W-1:0] sus, dwn;
    logic bk;
    logic [CNT_W-1:0] cnt;
    logic [EPOCH_W-1:0] ep;
    logic [IDX_W-1:0] node;
    bit all_regs;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.node_index = '0;
    in_ch.node_alive = 1'b0;
    gaps_on = 1'b0;
    pressure_on = 1'b0;
    pressure_held = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING[i]) offer_beat(OPENING[i][3:0], OPENING[i][4]);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      all_regs = (p < 4);
      case (p)
        0: begin
          sus = 0; dwn = 0; bk = 1'b1; cnt = 8; ep = 32'hFFFF_FFFF;
        end
        1: begin
          sus = 5; dwn = 2; bk = 1'b1; cnt = 15; ep = '0;
        end
        2: begin
          sus = 1; dwn = 4; bk = 1'b0; cnt = 0; ep = $urandom;
        end
        3: begin
          sus = 200; dwn = 255; bk = 1'b1; cnt = 1; ep = 32'hFFFF_FFFE;
        end
        default: begin
          sus = THR_W'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 4));
          dwn = THR_W'($urandom_range(1, 6));
          bk = ($urandom_range(0, 3) != 0);
          cnt = CNT_W'($urandom);
          ep = $urandom;
        end
      endcase
      program_reg(REG_SUSPECT, DATA_W'(sus));
      program_reg(REG_DOWN, DATA_W'(dwn));
      program_reg(REG_SHARDS, DATA_W'(cnt));
      if (all_regs || $urandom_range(0, 1)) program_reg(REG_BACKUPS, DATA_W'(bk));
      if (all_regs || $urandom_range(0, 1)) program_reg(REG_EPOCH, ep);
      gaps_on = (p != 5);
      pressure_on = (p == 5);
      if (p == 3) begin
        // miss count runs into saturation
        node = IDX_W'($urandom_range(0, NODES - 1));
        offer_beat(node, 1'b1);
        repeat (258) offer_beat(node, 1'b0);
      end else begin
        run_episodes(65);
      end
    end

    drain_results();
    $display("run covered %0d heartbeats and %0d reports: %0d state changes, %0d failovers",
             sb.beats, sb.reports, sb.changes, sb.failovers);
    $display("%0d register writes over %0d settings, %0d mismatches, %0d reports outstanding",
             sb.reg_writes, PHASES + 1, sb.mismatches, sb.expected_reports.size());
    if (sb.mismatches == 0 && sb.expected_reports.size() == 0) begin
      $display("[heartbeat_health_failover] OK");
    end else begin
      $display("[heartbeat_health_failover] ERROR");
    end
    $finish;
  end

endmodule
